### hw/rtl/assert_macros.svh
// assertion macros shared by the flattener rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bcf_pkg.sv
// shared widths and constants of the bezier curve flattener
// no dependencies; used by bcf_div, bcf_mul and the top level
`timescale 1ns / 1ps
`default_nettype none

package bcf_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_STEPS_DEF  = 63;

    // fixed field width of the subdivision count
    localparam int STEP_W = 6;

    // curve parameter t in unsigned q0.16, held in 17 bits so 1.0 fits
    localparam int            T_W   = 17;
    localparam logic [T_W-1:0] T_ONE = {1'b1, {(T_W-1){1'b0}}};

    // squares of s and t, and bernstein weights scaled by 2^48
    localparam int SQ_W    = 2 * T_W - 1;
    localparam int W_W     = 3 * (T_W - 1) + 1;
    localparam int FRAC    = 3 * (T_W - 1);
    localparam int QUAD_SH = FRAC - 2 * (T_W - 1);

    // weights split in two chunks for the dot product
    localparam int WLO_W = 24;
    localparam int WHI_W = W_W - WLO_W;

    // shared multiplier: unsigned a times signed b
    localparam int MA_W = WHI_W;
    localparam int MB_W = SQ_W + 1;
    localparam int MP_W = MA_W + 1 + MB_W;

endpackage

`default_nettype wire

### hw/rtl/bcf_div.sv
// radix-2 restoring divider for 1.0 / n, one quotient bit per cycle
// depends on bcf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcf_div #(
    parameter int DIV_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [bcf_pkg::T_W-1:0] o_quot,
    output logic [DIV_W-1:0]        o_rem
);

    localparam int CNT_W = $clog2(bcf_pkg::T_W + 1);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [bcf_pkg::T_W-1:0] r_num;
    logic [DIV_W-1:0]        r_rem;
    logic [DIV_W-1:0]        r_div;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_num[bcf_pkg::T_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    // step counter and done pulse
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(bcf_pkg::T_W);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= bcf_pkg::T_ONE;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[bcf_pkg::T_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

    // checks
    logic [bcf_pkg::T_W+DIV_W-1:0] chk_back;
    assign chk_back = (bcf_pkg::T_W+DIV_W)'(r_num) * (bcf_pkg::T_W+DIV_W)'(r_div)
                    + (bcf_pkg::T_W+DIV_W)'(r_rem);

    `ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `ASSERT_IMP(a_rem_small, i_clk, i_rst_n, r_done, r_rem < r_div, "remainder not below divisor")
    `ASSERT_IMP(a_div_exact, i_clk, i_rst_n, r_done,
                chk_back == (bcf_pkg::T_W+DIV_W)'(bcf_pkg::T_ONE), "quotient times n plus rest wrong")

endmodule

`default_nettype wire

### hw/rtl/bcf_mul.sv
// shared multiplier: unsigned operand a times signed operand b, registered product
// depends on bcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcf_mul (
    input  logic                             i_clk,
    input  logic        [bcf_pkg::MA_W-1:0]  i_a,
    input  logic signed [bcf_pkg::MB_W-1:0]  i_b,
    output logic signed [bcf_pkg::MP_W-1:0]  o_p
);

    logic signed [bcf_pkg::MA_W:0] a_ext;

    assign a_ext = {1'b0, i_a};

    // one product per cycle
    always_ff @(posedge i_clk) begin
        o_p <= a_ext * i_b;
    end

endmodule

`default_nettype wire

### hw/rtl/bezier_curve_flattener_top.sv
// bezier curve flattener, top level; uses bcf_pkg, bcf_div, bcf_mul, assert_macros.svh
// a curve with count n (zero counts as one) gives n+1 segments; one shared multiplier does all the multiplies
// after acceptance the divider forms 1.0 / n; each point then takes 23 multiplier issues,
// one write-back and one load into the output register, waiting while the output stalls
// s_axis tready is high only while idle
// i_rst_n is synchronous, active low, and clears the sequencer and valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bezier_curve_flattener_top #(
    parameter int COORD_BITS = bcf_pkg::COORD_BITS_DEF,
    parameter int MAX_STEPS  = bcf_pkg::MAX_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, step_count
    input  logic [((8*COORD_BITS+bcf_pkg::STEP_W+7)/8)*8-1:0] i_s_axis_tdata,
    // curve_degree
    input  logic i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic o_m_axis_tlast
);

    localparam int CB       = COORD_BITS;
    localparam int NW       = $clog2(MAX_STEPS + 1);
    localparam int OUT_BITS = 4 * CB;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int ACC_W    = CB + 50;
    localparam int RND_W    = ACC_W - bcf_pkg::FRAC;
    localparam int TERM_W   = bcf_pkg::MP_W + bcf_pkg::WLO_W;

    localparam logic [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-bcf_pkg::FRAC){1'b0}}, 1'b1, {(bcf_pkg::FRAC-1){1'b0}}};
    localparam logic signed [RND_W-1:0] RND_MAX = {3'b000, {(CB-1){1'b1}}};
    localparam logic signed [RND_W-1:0] RND_MIN = {3'b111, {(CB-1){1'b0}}};
    localparam logic [bcf_pkg::W_W+1:0] W_TOTAL =
        (bcf_pkg::W_W+2)'(1) << bcf_pkg::FRAC;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // micro-operations of one curve point
    localparam int         OP_W    = 5;
    localparam logic [4:0] OP_SS   = 5'd0;
    localparam logic [4:0] OP_TT   = 5'd1;
    localparam logic [4:0] OP_ST   = 5'd2;
    localparam logic [4:0] OP_S3   = 5'd3;
    localparam logic [4:0] OP_S2T  = 5'd4;
    localparam logic [4:0] OP_ST2  = 5'd5;
    localparam logic [4:0] OP_T3   = 5'd6;
    localparam logic [4:0] OP_DOT0 = 5'd7;
    localparam logic [4:0] OP_LAST = 5'd22;

    // control registers
    logic [1:0]      r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    logic            r_wb_valid, n_wb_valid;
    logic [OP_W-1:0] r_wb_op;
    logic            r_out_valid, n_out_valid;

    // curve and step registers
    logic                    r_cubic;
    logic signed [CB-1:0]    r_px [4];
    logic signed [CB-1:0]    r_py [4];
    logic [NW-1:0]           r_n;
    logic [NW-1:0]           r_i;
    logic [bcf_pkg::T_W-1:0] r_q0;
    logic [NW-1:0]           r_r0;
    logic [bcf_pkg::T_W-1:0] r_t;
    logic [NW-1:0]           r_tr;

    // evaluation registers
    logic [bcf_pkg::SQ_W-1:0] r_s2, r_t2, r_st;
    logic [bcf_pkg::W_W-1:0]  r_w [4];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [CB-1:0]     r_x, r_y;
    logic signed [CB-1:0]     r_prev_x, r_prev_y;

    // output register
    logic [OUT_BITS-1:0] r_out_data;
    logic                r_out_last;

    logic                    in_xfer, out_xfer, emit_go;
    logic [bcf_pkg::STEP_W-1:0] step_in;
    logic [NW-1:0]           n_clamped;
    logic                    div_done;
    logic [bcf_pkg::T_W-1:0] div_quot;
    logic [NW-1:0]           div_rem;
    logic [bcf_pkg::T_W-1:0] s_val;

    logic [OP_W-1:0]                 dot_op, wb_dot_op;
    logic [3:0]                      dot_idx, wb_idx;
    logic [bcf_pkg::MA_W-1:0]        mul_a;
    logic signed [bcf_pkg::MB_W-1:0] mul_b;
    logic signed [bcf_pkg::MP_W-1:0] mul_p;

    logic [bcf_pkg::W_W-1:0] prod_u, prod3;
    logic signed [TERM_W-1:0] term_wide;
    logic signed [ACC_W-1:0]  term, acc_base, acc_sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [CB-1:0]     sat;

    logic [NW:0]             tr_sum;
    logic                    tr_wrap;
    logic [bcf_pkg::W_W+1:0] w_sum;

    // handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;
    assign emit_go  = (r_state == ST_EMIT) && !r_wb_valid && (!r_out_valid || i_m_axis_tready);

    // count clamp: zero becomes one, large counts stop at the bound
    assign step_in = i_s_axis_tdata[8*CB +: bcf_pkg::STEP_W];
    always_comb begin
        if (step_in == '0) begin
            n_clamped = NW'(1);
        end else if (step_in > bcf_pkg::STEP_W'(MAX_STEPS)) begin
            n_clamped = NW'(MAX_STEPS);
        end else begin
            n_clamped = step_in[NW-1:0];
        end
    end

    bcf_div #(
        .DIV_W(NW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer),
        .i_divisor (n_clamped),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_wb_valid  = (r_state == ST_CALC);
        n_out_valid = emit_go ? 1'b1 : (out_xfer ? 1'b0 : r_out_valid);
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CALC;
                    n_op    = OP_SS;
                end
            end
            ST_CALC: begin
                n_op = r_op + 1'b1;
                if (r_op == OP_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_op    = OP_SS;
                    n_state = (r_i == r_n) ? ST_IDLE : ST_CALC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_SS;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // multiplier operand select; dot steps walk axis, point and weight chunk
    assign s_val   = bcf_pkg::T_ONE - r_t;
    assign dot_op  = r_op - OP_DOT0;
    assign dot_idx = dot_op[3:0];

    always_comb begin
        case (r_op)
            OP_SS: begin
                mul_a = bcf_pkg::MA_W'(s_val);
                mul_b = bcf_pkg::MB_W'(s_val);
            end
            OP_TT: begin
                mul_a = bcf_pkg::MA_W'(r_t);
                mul_b = bcf_pkg::MB_W'(r_t);
            end
            OP_ST: begin
                mul_a = bcf_pkg::MA_W'(s_val);
                mul_b = bcf_pkg::MB_W'(r_t);
            end
            OP_S3: begin
                mul_a = bcf_pkg::MA_W'(s_val);
                mul_b = bcf_pkg::MB_W'(r_s2);
            end
            OP_S2T: begin
                mul_a = bcf_pkg::MA_W'(r_t);
                mul_b = bcf_pkg::MB_W'(r_s2);
            end
            OP_ST2: begin
                mul_a = bcf_pkg::MA_W'(s_val);
                mul_b = bcf_pkg::MB_W'(r_t2);
            end
            OP_T3: begin
                mul_a = bcf_pkg::MA_W'(r_t);
                mul_b = bcf_pkg::MB_W'(r_t2);
            end
            default: begin
                if (dot_idx[0]) begin
                    mul_a = r_w[dot_idx[2:1]][bcf_pkg::W_W-1:bcf_pkg::WLO_W];
                end else begin
                    mul_a = bcf_pkg::MA_W'(r_w[dot_idx[2:1]][bcf_pkg::WLO_W-1:0]);
                end
                if (dot_idx[3]) begin
                    mul_b = bcf_pkg::MB_W'(r_py[dot_idx[2:1]]);
                end else begin
                    mul_b = bcf_pkg::MB_W'(r_px[dot_idx[2:1]]);
                end
            end
        endcase
    end

    bcf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // write-back arithmetic: weight scaling, accumulate, round and saturate
    assign wb_dot_op = r_wb_op - OP_DOT0;
    assign wb_idx    = wb_dot_op[3:0];
    assign prod_u    = mul_p[bcf_pkg::W_W-1:0];
    assign prod3     = prod_u + {prod_u[bcf_pkg::W_W-2:0], 1'b0};

    always_comb begin
        if (wb_idx[0]) begin
            term_wide = $signed({mul_p, {bcf_pkg::WLO_W{1'b0}}});
        end else begin
            term_wide = TERM_W'(mul_p);
        end
        term     = term_wide[ACC_W-1:0];
        acc_base = (wb_idx[2:0] == 3'd0) ? $signed(ACC_HALF) : r_acc;
        acc_sum  = acc_base + term;
        rnd      = acc_sum[ACC_W-1:bcf_pkg::FRAC];
        if (rnd > RND_MAX) begin
            sat = RND_MAX[CB-1:0];
        end else if (rnd < RND_MIN) begin
            sat = RND_MIN[CB-1:0];
        end else begin
            sat = rnd[CB-1:0];
        end
    end

    // quadratic weights are lifted by 2^16 so both degrees round at 2^48
    always_ff @(posedge i_clk) begin
        if (r_wb_valid) begin
            case (r_wb_op)
                OP_SS: r_s2 <= prod_u[bcf_pkg::SQ_W-1:0];
                OP_TT: r_t2 <= prod_u[bcf_pkg::SQ_W-1:0];
                OP_ST: r_st <= prod_u[bcf_pkg::SQ_W-1:0];
                OP_S3: begin
                    r_w[0] <= r_cubic ? prod_u
                            : bcf_pkg::W_W'({r_s2, {bcf_pkg::QUAD_SH{1'b0}}});
                end
                OP_S2T: begin
                    r_w[1] <= r_cubic ? prod3
                            : bcf_pkg::W_W'({r_st, {(bcf_pkg::QUAD_SH+1){1'b0}}});
                end
                OP_ST2: begin
                    r_w[2] <= r_cubic ? prod3
                            : bcf_pkg::W_W'({r_t2, {bcf_pkg::QUAD_SH{1'b0}}});
                end
                OP_T3: begin
                    r_w[3] <= r_cubic ? prod_u : '0;
                end
                default: begin
                    r_acc <= acc_sum;
                    if (wb_idx[2:0] == 3'd7) begin
                        if (wb_idx[3]) begin
                            r_y <= sat;
                        end else begin
                            r_x <= sat;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_op <= r_op;
    end

    // exact t = floor(i * 65536 / n) by stepping quotient and remainder
    assign tr_sum  = {1'b0, r_tr} + {1'b0, r_r0};
    assign tr_wrap = (tr_sum >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cubic <= i_s_axis_tuser;
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= i_s_axis_tdata[(2*k)*CB +: CB];
                r_py[k] <= i_s_axis_tdata[(2*k+1)*CB +: CB];
            end
            r_n  <= n_clamped;
            r_i  <= '0;
            r_t  <= '0;
            r_tr <= '0;
        end
        if (div_done) begin
            r_q0 <= div_quot;
            r_r0 <= div_rem;
        end
        if (emit_go) begin
            r_i  <= r_i + 1'b1;
            r_t  <= r_t + r_q0 + bcf_pkg::T_W'(tr_wrap);
            r_tr <= tr_wrap ? NW'(tr_sum - {1'b0, r_n}) : tr_sum[NW-1:0];
        end
    end

    // output register; the first segment of a curve starts at its own end point
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            if (r_i == '0) begin
                r_out_data <= {r_y, r_x, r_y, r_x};
            end else begin
                r_out_data <= {r_y, r_x, r_prev_y, r_prev_x};
            end
            r_out_last <= (r_i == r_n);
            r_prev_x   <= r_x;
            r_prev_y   <= r_y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tlast  = r_out_last;

    // checks
    assign w_sum = (bcf_pkg::W_W+2)'(r_w[0]) + (bcf_pkg::W_W+2)'(r_w[1])
                 + (bcf_pkg::W_W+2)'(r_w[2]) + (bcf_pkg::W_W+2)'(r_w[3]);

    `ASSERT_IMP(a_div_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV,
                "divider finished outside its wait state")
    `ASSERT_IMP(a_t_ends_one, i_clk, i_rst_n, emit_go && (r_i == r_n), r_t == bcf_pkg::T_ONE,
                "last sample is not at t of one")
    `ASSERT_IMP(a_rem_below_n, i_clk, i_rst_n, r_state == ST_CALC, r_tr < r_n,
                "t remainder out of range")
    `ASSERT_IMP(a_weights_sum, i_clk, i_rst_n,
                (r_state == ST_CALC) && (r_op == OP_DOT0 + 5'd1), w_sum == W_TOTAL,
                "bernstein weights do not sum to one")

endmodule

`default_nettype wire

### sim/bezier_curve_flattener_top_tb.sv
// self-checking testbench for the bezier curve flattener top level
// uses bcf_pkg and bezier_curve_flattener_top; a bernstein-form predictor checks each segment
`timescale 1ns / 1ps

module bezier_curve_flattener_top_tb;

    localparam int CW       = bcf_pkg::COORD_BITS_DEF;
    localparam int SW       = bcf_pkg::STEP_W;
    localparam int S_DATA_W = ((8 * CW + SW + 7) / 8) * 8;
    localparam int M_DATA_W = ((4 * CW + 7) / 8) * 8;

    localparam int RANDOM_CURVES = 155;
    localparam int CALM_CURVES   = 30;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 100;

    localparam logic [CW-1:0] C_MAX  = 16'h7FFF;
    localparam logic [CW-1:0] C_MIN  = 16'h8000;
    localparam logic [CW-1:0] C_ZERO = 16'h0000;

    typedef enum bit { DEG_QUAD = 1'b0, DEG_CUBIC = 1'b1 } degree_e;

    typedef struct packed {
        degree_e              degree;
        logic [3:0][CW-1:0]   px;
        logic [3:0][CW-1:0]   py;
        logic [SW-1:0]        steps;
    } curve_t;

    typedef struct packed {
        curve_t        crv;
        logic          typed;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
    } curve_row_t;

    typedef struct packed {
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic          last;
    } segment_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic                o_m_axis_tlast;

    segment_t   pending_segments[$];
    curve_row_t directed_rows[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         calm_tail = 1'b0;

    // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, step_count
    // curve_degree on tuser; seg_start_x, seg_start_y, seg_end_x, seg_end_y on m tdata
    bezier_curve_flattener_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one axis of the curve at parameter t (q0.16), exact sum, one rounding, saturation
    function automatic logic [CW-1:0] bernstein_axis(degree_e degree, logic [3:0][CW-1:0] p,
                                                     int unsigned t);
        logic [63:0]        s;
        logic [63:0]        u;
        logic [63:0]        w[4];
        logic signed [79:0] acc;
        logic signed [79:0] coord;
        logic signed [79:0] half;
        int                 frac;
        s = 65536 - t;
        u = t;
        if (degree == DEG_CUBIC) begin
            w[0] = s * s * s;
            w[1] = 3 * s * s * u;
            w[2] = 3 * s * u * u;
            w[3] = u * u * u;
            frac = 48;
        end else begin
            w[0] = s * s;
            w[1] = 2 * s * u;
            w[2] = u * u;
            w[3] = 0;
            frac = 32;
        end
        acc = 0;
        for (int k = 0; k < 4; k++) begin
            coord = $signed(p[k]);
            acc += $signed({16'd0, w[k]}) * coord;
        end
        half = 80'sd1 <<< (frac - 1);
        acc  = (acc + half) >>> frac;
        if (acc > 80'sd32767)
            acc = 80'sd32767;
        if (acc < -80'sd32768)
            acc = -80'sd32768;
        return acc[CW-1:0];
    endfunction

    // expected segments of one curve; typed rows give one constant point for every sample
    function automatic void plan_segments(curve_row_t row);
        int unsigned   n;
        int unsigned   t;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] prev_x;
        logic [CW-1:0] prev_y;
        segment_t      seg;
        n = (row.crv.steps == 0) ? 1 : row.crv.steps;
        prev_x = '0;
        prev_y = '0;
        for (int unsigned i = 0; i <= n; i++) begin
            t = (i * 65536) / n;
            if (row.typed) begin
                x = row.tx;
                y = row.ty;
            end else begin
                x = bernstein_axis(row.crv.degree, row.crv.px, t);
                y = bernstein_axis(row.crv.degree, row.crv.py, t);
            end
            if (i == 0) begin
                prev_x = x;
                prev_y = y;
            end
            seg.sx   = prev_x;
            seg.sy   = prev_y;
            seg.ex   = x;
            seg.ey   = y;
            seg.last = (i == n);
            pending_segments = {pending_segments, seg};
            prev_x = x;
            prev_y = y;
        end
    endfunction

    function automatic void add_row(degree_e degree, logic [CW-1:0] x0, logic [CW-1:0] y0,
                                    logic [CW-1:0] x1, logic [CW-1:0] y1,
                                    logic [CW-1:0] x2, logic [CW-1:0] y2,
                                    logic [CW-1:0] x3, logic [CW-1:0] y3,
                                    logic [SW-1:0] steps, logic typed,
                                    logic [CW-1:0] tx, logic [CW-1:0] ty);
        curve_row_t row;
        row.crv.degree = degree;
        row.crv.px     = {x3, x2, x1, x0};
        row.crv.py     = {y3, y2, y1, y0};
        row.crv.steps  = steps;
        row.typed      = typed;
        row.tx         = tx;
        row.ty         = ty;
        directed_rows = {directed_rows, row};
    endfunction

    // coordinates biased toward the extremes
    function automatic logic [CW-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2: return C_ZERO;
            default: return r[CW-1:0];
        endcase
    endfunction

    // mostly short curves, a few up to the largest count
    function automatic logic [SW-1:0] rand_steps();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return SW'($urandom_range(0, 8));
        else if (pick < 19)
            return SW'($urandom_range(9, 31));
        return SW'($urandom_range(32, 63));
    endfunction

    function automatic void check_field(string what, logic [CW-1:0] want, logic [CW-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // drive one curve, with an optional gap in front, and predict it on its transfer
    task automatic send_curve(curve_row_t row);
        logic [S_DATA_W-1:0] d;
        if (!calm_tail && $urandom_range(0, 2) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        d = '0;
        for (int k = 0; k < 4; k++) begin
            d[2 * k * CW +: CW]       = row.crv.px[k];
            d[(2 * k + 1) * CW +: CW] = row.crv.py[k];
        end
        d[8 * CW +: SW] = row.crv.steps;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= row.crv.degree;
        do
            @(posedge i_clk);
        while (!(i_s_axis_tvalid && o_s_axis_tready));
        plan_segments(row);
    endtask

    // receiver: ready runs broken by stall bursts, none in the calm tail
    initial begin
        forever begin
            if (!calm_tail && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // segment checker and watchdog
    always @(posedge i_clk) begin
        segment_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_segments.size() == 0) begin
                $display("%0t ns: unexpected segment, expected none, actual %h last %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_segments.pop_front();
                check_field("seg_start_x", want.sx, o_m_axis_tdata[0 * CW +: CW]);
                check_field("seg_start_y", want.sy, o_m_axis_tdata[1 * CW +: CW]);
                check_field("seg_end_x", want.ex, o_m_axis_tdata[2 * CW +: CW]);
                check_field("seg_end_y", want.ey, o_m_axis_tdata[3 * CW +: CW]);
                check_field("last_segment", {15'd0, want.last}, {15'd0, o_m_axis_tlast});
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        curve_row_t row;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // constant curves: every sample is the common point
        add_row(DEG_QUAD, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                6'd0, 1'b1, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                6'd1, 1'b1, C_MAX, C_MAX);
        add_row(DEG_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                6'd63, 1'b1, C_MIN, C_MIN);
        // quadratic ignores the fourth point
        add_row(DEG_QUAD, 16'h1234, 16'hEDCC, 16'h1234, 16'hEDCC, 16'h1234, 16'hEDCC,
                C_MIN, C_MAX, 6'd5, 1'b1, 16'h1234, 16'hEDCC);
        // full-scale swings
        add_row(DEG_QUAD, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_ZERO, C_ZERO,
                6'd63, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                6'd63, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
                6'd7, 1'b0, C_ZERO, C_ZERO);
        // alternating bit patterns on every field
        add_row(DEG_CUBIC, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                16'hAAAA, 16'h5555, 6'h2A, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_QUAD, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                16'h5555, 16'hAAAA, 6'h15, 1'b0, C_ZERO, C_ZERO);
        // cubic with zero count
        add_row(DEG_CUBIC, 16'h0001, 16'hFFFF, 16'h0010, 16'hFFF0, 16'h0100, 16'hFF00,
                16'h1000, 16'hF000, 6'd0, 1'b0, C_ZERO, C_ZERO);
        // small values where rounding ties show up
        add_row(DEG_QUAD, C_ZERO, C_ZERO, 16'h0001, 16'hFFFF, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                6'd2, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, C_ZERO, C_ZERO, 16'h0003, 16'hFFFD, 16'hFFFD, 16'h0003,
                C_ZERO, C_ZERO, 6'd3, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_QUAD, 16'h0100, 16'hFF00, 16'h7000, 16'h9000, 16'hC000, 16'h4000,
                16'hFFFF, 16'hFFFF, 6'd1, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001,
                16'h0001, 16'hFFFF, 6'd63, 1'b0, C_ZERO, C_ZERO);
        add_row(DEG_CUBIC, 16'h4000, 16'hC000, C_MIN, C_MAX, C_MAX, C_MIN, 16'hC000, 16'h4000,
                6'd11, 1'b0, C_ZERO, C_ZERO);

        foreach (directed_rows[r])
            send_curve(directed_rows[r]);

        // random curves, calm tail at the end
        for (int idx = 0; idx < RANDOM_CURVES; idx++) begin
            if (idx >= RANDOM_CURVES - CALM_CURVES)
                calm_tail = 1'b1;
            row.crv.degree = degree_e'($urandom_range(0, 1));
            for (int k = 0; k < 4; k++) begin
                row.crv.px[k] = rand_coord();
                row.crv.py[k] = rand_coord();
            end
            row.crv.steps = rand_steps();
            row.typed     = 1'b0;
            row.tx        = '0;
            row.ty        = '0;
            send_curve(row);
        end
        i_s_axis_tvalid <= 1'b0;

        // drain, then watch for stray segments
        while (pending_segments.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
